/* hw/rtl/hsj_pkg.sv */
// ----------------------------------------------------------------------------
// hsj_pkg
// Shared types and constants of the Halton sub-pixel jitter block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hsj_pkg;

   // Ternary places of the base-3 radical inverse.
   localparam int TERN_DIGITS = 21;

   // 3^21, the scale of the base-3 radical inverse (needs 34 bits).
   localparam int TERN_W = 34;
   localparam logic [TERN_W-1:0] TERN_POW = 34'd10460353203;

   // Reciprocal of three: floor(v / 3) == (v * TERN_RECIP) >> 33 for any 32-bit v.
   localparam logic [31:0] TERN_RECIP = 32'hAAAA_AAAB;

   // Divisor width: 3^21 * 32767 stays below 2^49.
   localparam int DIV_W = 49;

   // Quotient bits: every magnitude stays at or below 2^30.
   localparam int QUO_W = 31;

   // Step counter, wide enough for the longer of the two serial phases.
   localparam int CNT_W = 5;

   // Configuration register width and register select codes (paddr[2]).
   localparam int DIM_W = 15;
   localparam logic CSR_WIDTH_SEL  = 1'b0;
   localparam logic CSR_HEIGHT_SEL = 1'b1;

   // Load and step strobes shared by the serial units.
   typedef struct packed {
      logic load;
      logic step;
   } hsj_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIGITS,
      ST_LOAD,
      ST_DIVIDE,
      ST_FINISH
   } hsj_state_type;

endpackage

`default_nettype wire

/* hw/rtl/hsj_ternary.sv */
// ----------------------------------------------------------------------------
// hsj_ternary
// Serial base-3 digit reversal: one ternary digit per step, LSB digit first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsj_ternary (
   input  wire logic                        clock,
   input  wire hsj_pkg::hsj_ctl_type        ctl,
   input  wire logic [31:0]                 value,
   output      logic [hsj_pkg::TERN_W-1:0]  reversed
);

   logic [31:0]                value_ff;
   logic [31:0]                value_in;
   logic [hsj_pkg::TERN_W-1:0] rev_ff;
   logic [hsj_pkg::TERN_W-1:0] rev_in;
   logic [63:0]                recip_prod;
   logic [30:0]                quot;
   logic [31:0]                three_quot;
   logic [31:0]                rem_full;
   logic [1:0]                 digit;

   // The quotient by three comes from a multiply by the reciprocal; the
   // remainder is what is left after subtracting three times the quotient.
   always_comb begin
      recip_prod = 64'(value_ff) * 64'(hsj_pkg::TERN_RECIP);
      quot       = recip_prod[63:33];
      three_quot = {quot, 1'b0} + {1'b0, quot};
      rem_full   = value_ff - three_quot;
      digit      = rem_full[1:0];
      value_in   = value_ff;
      rev_in     = rev_ff;
      if (ctl.load) begin
         value_in = value;
         rev_in   = '0;
      end else if (ctl.step) begin
         value_in = {1'b0, quot};
         rev_in   = {rev_ff[hsj_pkg::TERN_W-2:0], 1'b0} + rev_ff
                    + hsj_pkg::TERN_W'(digit);
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      rev_ff   <= rev_in;
   end

   assign reversed = rev_ff;

endmodule

`default_nettype wire

/* hw/rtl/hsj_divider.sv */
// ----------------------------------------------------------------------------
// hsj_divider
// Restoring divider that takes one numerator bit and yields one quotient bit
// per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hsj_divider (
   input  wire logic                        clock,
   input  wire hsj_pkg::hsj_ctl_type        ctl,
   input  wire logic [hsj_pkg::DIV_W-1:0]   rem_init,
   input  wire logic [hsj_pkg::QUO_W-1:0]   num_bits,
   input  wire logic [hsj_pkg::DIV_W-1:0]   divisor,
   output      logic [hsj_pkg::QUO_W-1:0]   quotient
);

   logic [hsj_pkg::DIV_W-1:0] rem_ff;
   logic [hsj_pkg::DIV_W-1:0] rem_in;
   logic [hsj_pkg::QUO_W-1:0] num_ff;
   logic [hsj_pkg::QUO_W-1:0] num_in;
   logic [hsj_pkg::QUO_W-1:0] quo_ff;
   logic [hsj_pkg::QUO_W-1:0] quo_in;
   logic [hsj_pkg::DIV_W-1:0] div_ff;
   logic [hsj_pkg::DIV_W-1:0] div_in;
   logic [hsj_pkg::DIV_W:0]   trial;
   logic [hsj_pkg::DIV_W:0]   diff;
   logic                      fits;

   // The partial remainder always stays below the divisor, so one bit of
   // headroom covers the shifted trial value.
   always_comb begin
      trial  = {rem_ff, num_ff[hsj_pkg::QUO_W-1]};
      diff   = trial - {1'b0, div_ff};
      fits   = (trial >= {1'b0, div_ff});
      rem_in = rem_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (ctl.load) begin
         rem_in = rem_init;
         num_in = num_bits;
         quo_in = '0;
         div_in = divisor;
      end else if (ctl.step) begin
         rem_in = fits ? diff[hsj_pkg::DIV_W-1:0] : trial[hsj_pkg::DIV_W-1:0];
         num_in = {num_ff[hsj_pkg::QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[hsj_pkg::QUO_W-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* hw/rtl/halton_subpixel_jitter.sv */
// ----------------------------------------------------------------------------
// halton_subpixel_jitter
// Halton (2,3) sub-pixel jitter offsets for temporal anti-aliasing.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Beat contents
// req       in         req_valid/stall    jitter_index (32 b unsigned)
// rsp       out        rsp_valid/stall    jitter_x, jitter_y (31 b signed Q1.30)
// csr       in/out     APB psel/penable   image_width @0x0, image_height @0x4
//
// An item passes through ternary digit extraction (one digit per cycle by a
// multiply with the reciprocal of three), a divider load step, the divide phase
// (one quotient bit per step), a step that fills the output register and the
// idle state, in which req_stall is low and a new item can be taken.
// A result waits in the output register; a stall on rsp holds the block only when
// a second result is ready behind it. Reset is synchronous and sets 1920x1080.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module halton_subpixel_jitter (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input channel
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [31:0]         req_jitter_index,
   // Result channel
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic signed [30:0]  rsp_jitter_x,
   output      logic signed [30:0]  rsp_jitter_y,
   // Configuration port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [2:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output      logic [31:0]         prdata,
   output      logic                pready
);

   localparam int DW = hsj_pkg::DIM_W;
   localparam int TW = hsj_pkg::TERN_W;
   localparam int VW = hsj_pkg::DIV_W;
   localparam int QW = hsj_pkg::QUO_W;
   localparam int CW = hsj_pkg::CNT_W;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes land on the access cycle; the low two
   // address bits are a byte offset and do not select a register.
   // ---------------------------------------------------------------------
   logic [DW-1:0] width_ff;
   logic [DW-1:0] width_in;
   logic [DW-1:0] height_ff;
   logic [DW-1:0] height_in;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         case (paddr[2])
            hsj_pkg::CSR_WIDTH_SEL:  width_in  = pwdata[DW-1:0];
            hsj_pkg::CSR_HEIGHT_SEL: height_in = pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         hsj_pkg::CSR_WIDTH_SEL:  prdata = {(32-DW)'(0), width_ff};
         hsj_pkg::CSR_HEIGHT_SEL: prdata = {(32-DW)'(0), height_ff};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DW'(1920);
         height_ff <= DW'(1080);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   hsj_pkg::hsj_state_type state_ff;
   hsj_pkg::hsj_state_type state_in;
   logic [CW-1:0]          cnt_ff;
   logic [CW-1:0]          cnt_in;
   logic                   req_take;
   logic                   rsp_load;
   hsj_pkg::hsj_ctl_type   tern_ctl;
   hsj_pkg::hsj_ctl_type   div_ctl;

   assign req_stall = (state_ff != hsj_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      tern_ctl.load = 1'b0;
      tern_ctl.step = 1'b0;
      div_ctl.load  = 1'b0;
      div_ctl.step  = 1'b0;
      rsp_load      = 1'b0;
      case (state_ff)
         hsj_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               tern_ctl.load = 1'b1;
               state_in      = hsj_pkg::ST_DIGITS;
            end
         end
         hsj_pkg::ST_DIGITS: begin
            tern_ctl.step = 1'b1;
            cnt_in        = cnt_ff + CW'(1);
            if (cnt_ff == CW'(hsj_pkg::TERN_DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = hsj_pkg::ST_LOAD;
            end
         end
         hsj_pkg::ST_LOAD: begin
            div_ctl.load = 1'b1;
            state_in     = hsj_pkg::ST_DIVIDE;
         end
         hsj_pkg::ST_DIVIDE: begin
            div_ctl.step = 1'b1;
            cnt_in       = cnt_ff + CW'(1);
            if (cnt_ff == CW'(QW - 1)) begin
               cnt_in   = '0;
               state_in = hsj_pkg::ST_FINISH;
            end
         end
         hsj_pkg::ST_FINISH: begin
            // Wait here only while an earlier result still sits unclaimed.
            if (!rsp_valid || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = hsj_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hsj_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsj_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence position and the base-3 digit reversal.
   // ---------------------------------------------------------------------
   logic [31:0]   pos_ff;
   logic [31:0]   pos_in;
   logic [TW-1:0] tern_rev;

   assign pos_in = req_take ? (req_jitter_index + 32'd1) : pos_ff;

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   hsj_ternary u_ternary (
      .clock    (clock),
      .ctl      (tern_ctl),
      .value    (pos_in),
      .reversed (tern_rev)
   );

   // ---------------------------------------------------------------------
   // The y divisor 3^21 * height is built by shift and add during the digit
   // phase, one height bit per cycle. A zero dimension counts as one.
   // ---------------------------------------------------------------------
   logic [VW-1:0] pow_sh_ff;
   logic [VW-1:0] pow_sh_in;
   logic [DW-1:0] hgt_sh_ff;
   logic [DW-1:0] hgt_sh_in;
   logic [VW-1:0] ydiv_ff;
   logic [VW-1:0] ydiv_in;

   always_comb begin
      pow_sh_in = pow_sh_ff;
      hgt_sh_in = hgt_sh_ff;
      ydiv_in   = ydiv_ff;
      if (req_take) begin
         pow_sh_in = VW'(hsj_pkg::TERN_POW);
         hgt_sh_in = (height_ff == '0) ? DW'(1) : height_ff;
         ydiv_in   = '0;
      end else if (tern_ctl.step) begin
         if (hgt_sh_ff[0]) begin
            ydiv_in = ydiv_ff + pow_sh_ff;
         end
         pow_sh_in = {pow_sh_ff[VW-2:0], 1'b0};
         hgt_sh_in = {1'b0, hgt_sh_ff[DW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      pow_sh_ff <= pow_sh_in;
      hgt_sh_ff <= hgt_sh_in;
      ydiv_ff   <= ydiv_in;
   end

   // ---------------------------------------------------------------------
   // Divider operands. x: |bitrev(n) - 2^31| / (2 * width).
   // y: (|2t - 3^21| << 30) / (3^21 * height). The dividers shift in the
   // numerator's low 31 bits; the bits above them seed the remainder.
   // ---------------------------------------------------------------------
   logic [31:0]    bit_rev;
   logic           negx;
   logic [31:0]    magx;
   logic [TW:0]    twice_t;
   logic           negy;
   logic [TW:0]    magy_full;
   logic [TW-1:0]  magy;
   logic [DW:0]    xdiv;
   logic           negx_ff;
   logic           negx_in;
   logic           negy_ff;
   logic           negy_in;
   logic [QW-1:0]  quo_x;
   logic [QW-1:0]  quo_y;

   always_comb begin
      for (int i = 0; i < 32; i++) begin
         bit_rev[i] = pos_ff[31-i];
      end
      negx      = !bit_rev[31];
      magx      = negx ? (32'h8000_0000 - bit_rev) : {1'b0, bit_rev[30:0]};
      twice_t   = {tern_rev, 1'b0};
      negy      = (twice_t < {1'b0, hsj_pkg::TERN_POW});
      magy_full = negy ? ({1'b0, hsj_pkg::TERN_POW} - twice_t)
                       : (twice_t - {1'b0, hsj_pkg::TERN_POW});
      magy      = magy_full[TW-1:0];
      xdiv      = (width_ff == '0) ? (DW+1)'(2) : {width_ff, 1'b0};
      negx_in   = div_ctl.load ? negx : negx_ff;
      negy_in   = div_ctl.load ? negy : negy_ff;
   end

   always_ff @(posedge clock) begin
      negx_ff <= negx_in;
      negy_ff <= negy_in;
   end

   hsj_divider u_div_x (
      .clock    (clock),
      .ctl      (div_ctl),
      .rem_init (VW'(magx[31])),
      .num_bits (magx[30:0]),
      .divisor  (VW'(xdiv)),
      .quotient (quo_x)
   );

   hsj_divider u_div_y (
      .clock    (clock),
      .ctl      (div_ctl),
      .rem_init (VW'(magy[TW-1:1])),
      .num_bits ({magy[0], (QW-1)'(0)}),
      .divisor  (ydiv_ff),
      .quotient (quo_y)
   );

   // ---------------------------------------------------------------------
   // Output register: sign applied to the magnitudes.
   // ---------------------------------------------------------------------
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [QW-1:0] rsp_x_ff;
   logic [QW-1:0] rsp_x_in;
   logic [QW-1:0] rsp_y_ff;
   logic [QW-1:0] rsp_y_in;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_x_in     = negx_ff ? (QW'(0) - quo_x) : quo_x;
         rsp_y_in     = negy_ff ? (QW'(0) - quo_y) : quo_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_jitter_x = rsp_x_ff;
   assign rsp_jitter_y = rsp_y_ff;

endmodule

`default_nettype wire
